// ----- rtl/cht_pkg.sv -----
// Shared operation and status codes for the chained hash table engine.
package cht_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

// ----- rtl/cht_ram.sv -----
// Single-port-write, single-port-read memory with registered read data.
module cht_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/chained_hash_table_engine.sv -----
// Top level of the chained hash table engine: sequencer, free list and table memories.
//
// One transaction is taken when start is high and busy is low; busy stays high until the
// result has been produced, and the result then appears for exactly one cycle with done
// high. The receiver cannot stall it, so it must take every result in that cycle. Lookup,
// remove and insert walk the bucket's chain, comparing one entry per cycle (limited by
// the single read port of the slot memories); insert takes its slot from the free stack
// when that holds one. Clear sweeps all ENTRIES bucket heads, one per cycle. After reset
// the same sweep runs with busy high before the first transaction is accepted.
module chained_hash_table_engine
    import cht_pkg::*;
#(
    parameter int ENTRIES    = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int HASH_BITS  = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                mode,
    input  logic [31:0]               key_hash,
    input  logic [31:0]               key,
    input  logic [31:0]               entry_value,
    output logic                      done,
    output logic [1:0]                status,
    output logic                      found,
    output logic [31:0]               out_key,
    output logic [31:0]               out_value,
    output logic [$clog2(ENTRIES):0]  entry_count,
    output logic                      is_empty
);

    localparam int IW = $clog2(ENTRIES);
    localparam int PW = IW + 1;
    localparam logic [PW-1:0] NIL = PW'(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CLR    = 9'b000000010,
        S_HEAD   = 9'b000000100,
        S_CMP    = 9'b000001000,
        S_DECIDE = 9'b000010000,
        S_POP    = 9'b000100000,
        S_INS    = 9'b001000000,
        S_RM1    = 9'b010000000,
        S_RM2    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [HASH_BITS-1:0]  hash_reg, hash_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [IW-1:0]         bucket_reg, bucket_next;
    mode_t                 mode_reg, mode_next;
    logic                  clr_op_reg, clr_op_next;
    logic [IW-1:0]         clr_idx_reg, clr_idx_next;
    logic [PW-1:0]         head_reg, head_next;
    logic [PW-1:0]         cur_reg, cur_next;
    logic [PW-1:0]         prev_reg, prev_next;
    logic [PW-1:0]         nxt_reg, nxt_next;
    logic [PW-1:0]         hole_reg, hole_next;
    logic [IW-1:0]         steps_reg, steps_next;
    logic                  hit_reg, hit_next;
    logic [KEY_BITS-1:0]   fkey_reg, fkey_next;
    logic [VALUE_BITS-1:0] fval_reg, fval_next;
    logic [PW-1:0]         free_top_reg, free_top_next;
    logic [PW-1:0]         hw_reg, hw_next;
    logic [PW-1:0]         total_reg, total_next;

    logic                  done_reg;
    status_t               status_reg;
    logic                  found_reg;
    logic [31:0]           out_key_reg, out_value_reg;
    logic [PW-1:0]         count_reg;
    logic                  empty_reg;

    logic                  fin;
    status_t               fin_status;

    logic [63:0]           in_hash_ext, in_key_ext, in_val_ext, in_bucket_ext;
    logic [HASH_BITS-1:0]  in_hash;
    logic [63:0]           fkey_ext, fval_ext;

    logic                  heads_we;
    logic [IW-1:0]         heads_waddr, heads_raddr;
    logic [PW-1:0]         heads_wdata, head_rd;
    logic                  links_we;
    logic [IW-1:0]         links_waddr, node_raddr;
    logic [PW-1:0]         links_wdata, link_rd;
    logic                  data_we;
    logic [HASH_BITS-1:0]  hash_rd;
    logic [KEY_BITS-1:0]   key_rd;
    logic [VALUE_BITS-1:0] val_rd;

    assign in_hash_ext   = 64'(key_hash);
    assign in_hash       = in_hash_ext[HASH_BITS-1:0];
    assign in_bucket_ext = 64'(in_hash);
    assign in_key_ext    = 64'(key);
    assign in_val_ext    = 64'(entry_value);
    assign fkey_ext      = 64'(fkey_reg);
    assign fval_ext      = 64'(fval_reg);

    cht_ram #(.DEPTH(ENTRIES), .WIDTH(PW)) u_heads (
        .clk(clk), .we(heads_we), .waddr(heads_waddr), .wdata(heads_wdata),
        .raddr(heads_raddr), .rdata(head_rd)
    );

    cht_ram #(.DEPTH(ENTRIES), .WIDTH(PW)) u_links (
        .clk(clk), .we(links_we), .waddr(links_waddr), .wdata(links_wdata),
        .raddr(node_raddr), .rdata(link_rd)
    );

    cht_ram #(.DEPTH(ENTRIES), .WIDTH(HASH_BITS)) u_hashes (
        .clk(clk), .we(data_we), .waddr(hole_reg[IW-1:0]), .wdata(hash_reg),
        .raddr(node_raddr), .rdata(hash_rd)
    );

    cht_ram #(.DEPTH(ENTRIES), .WIDTH(KEY_BITS)) u_keys (
        .clk(clk), .we(data_we), .waddr(hole_reg[IW-1:0]), .wdata(key_reg),
        .raddr(node_raddr), .rdata(key_rd)
    );

    cht_ram #(.DEPTH(ENTRIES), .WIDTH(VALUE_BITS)) u_values (
        .clk(clk), .we(data_we), .waddr(hole_reg[IW-1:0]), .wdata(val_reg),
        .raddr(node_raddr), .rdata(val_rd)
    );

    // memory ports
    always_comb
    begin
        heads_raddr = (state_reg == S_IDLE) ? in_bucket_ext[IW-1:0] : bucket_reg;
        heads_we    = 1'b0;
        heads_waddr = bucket_reg;
        heads_wdata = hole_reg;
        links_we    = 1'b0;
        links_waddr = hole_reg[IW-1:0];
        links_wdata = head_reg;
        data_we     = 1'b0;
        unique case (state_reg)
            S_HEAD:   node_raddr = head_rd[IW-1:0];
            S_CMP:    node_raddr = link_rd[IW-1:0];
            S_DECIDE: node_raddr = free_top_reg[IW-1:0];
            default:  node_raddr = cur_reg[IW-1:0];
        endcase
        unique case (state_reg)
            S_CLR:
            begin
                heads_we    = 1'b1;
                heads_waddr = clr_idx_reg;
                heads_wdata = NIL;
            end
            S_INS:
            begin
                heads_we = 1'b1;
                links_we = 1'b1;
                data_we  = 1'b1;
            end
            S_RM1:
            begin
                if (prev_reg[IW])
                begin
                    heads_we    = 1'b1;
                    heads_wdata = nxt_reg;
                end
                else
                begin
                    links_we    = 1'b1;
                    links_waddr = prev_reg[IW-1:0];
                    links_wdata = nxt_reg;
                end
            end
            S_RM2:
            begin
                links_we    = 1'b1;
                links_waddr = cur_reg[IW-1:0];
                links_wdata = free_top_reg;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        hash_next     = hash_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        bucket_next   = bucket_reg;
        mode_next     = mode_reg;
        clr_op_next   = clr_op_reg;
        clr_idx_next  = clr_idx_reg;
        head_next     = head_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        nxt_next      = nxt_reg;
        hole_next     = hole_reg;
        steps_next    = steps_reg;
        hit_next      = hit_reg;
        fkey_next     = fkey_reg;
        fval_next     = fval_reg;
        free_top_next = free_top_reg;
        hw_next       = hw_reg;
        total_next    = total_reg;
        fin           = 1'b0;
        fin_status    = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    hash_next   = in_hash;
                    key_next    = in_key_ext[KEY_BITS-1:0];
                    val_next    = in_val_ext[VALUE_BITS-1:0];
                    bucket_next = in_bucket_ext[IW-1:0];
                    mode_next   = mode_t'(mode);
                    hit_next    = 1'b0;
                    if (mode_t'(mode) == MODE_CLEAR)
                    begin
                        clr_op_next   = 1'b1;
                        clr_idx_next  = '0;
                        free_top_next = NIL;
                        hw_next       = '0;
                        total_next    = '0;
                        state_next    = S_CLR;
                    end
                    else
                    begin
                        clr_op_next = 1'b0;
                        state_next  = S_HEAD;
                    end
                end
            end
            S_CLR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST)
                begin
                    state_next = S_IDLE;
                    fin        = clr_op_reg;
                end
            end
            S_HEAD:
            begin
                head_next  = head_rd;
                cur_next   = head_rd;
                prev_next  = NIL;
                steps_next = '0;
                state_next = head_rd[IW] ? S_DECIDE : S_CMP;
            end
            S_CMP:
            begin
                if (hash_rd == hash_reg)
                begin
                    hit_next   = 1'b1;
                    fkey_next  = key_rd;
                    fval_next  = val_rd;
                    nxt_next   = link_rd;
                    state_next = S_DECIDE;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    steps_next = steps_reg + 1'b1;
                    if (link_rd[IW] || steps_reg == LAST)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                unique case (mode_reg)
                    MODE_LOOKUP:
                    begin
                        fin        = 1'b1;
                        fin_status = hit_reg ? ST_OK : ST_NOT_FOUND;
                        state_next = S_IDLE;
                    end
                    MODE_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            state_next = S_RM1;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            fin_status = ST_NOT_FOUND;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_DUPLICATE;
                            state_next = S_IDLE;
                        end
                        else if (total_reg >= NIL)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_FULL;
                            state_next = S_IDLE;
                        end
                        else if (!free_top_reg[IW])
                        begin
                            hole_next  = free_top_reg;
                            state_next = S_POP;
                        end
                        else if (hw_reg < NIL)
                        begin
                            hole_next  = hw_reg;
                            hw_next    = hw_reg + 1'b1;
                            state_next = S_INS;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            fin_status = ST_FULL;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP:
            begin
                free_top_next = link_rd;
                state_next    = S_INS;
            end
            S_INS:
            begin
                total_next = total_reg + 1'b1;
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            S_RM1:
            begin
                state_next = S_RM2;
            end
            S_RM2:
            begin
                free_top_next = cur_reg;
                if (total_reg != '0)
                begin
                    total_next = total_reg - 1'b1;
                end
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_op_reg   <= 1'b0;
            clr_idx_reg  <= '0;
            free_top_reg <= NIL;
            hw_reg       <= '0;
            total_reg    <= '0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_op_reg   <= clr_op_next;
            clr_idx_reg  <= clr_idx_next;
            free_top_reg <= free_top_next;
            hw_reg       <= hw_next;
            total_reg    <= total_next;
            done_reg     <= fin;
            hit_reg      <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg   <= hash_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        bucket_reg <= bucket_next;
        mode_reg   <= mode_next;
        head_reg   <= head_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        hole_reg   <= hole_next;
        steps_reg  <= steps_next;
        fkey_reg   <= fkey_next;
        fval_reg   <= fval_next;
        if (fin)
        begin
            status_reg    <= fin_status;
            found_reg     <= hit_reg && !clr_op_reg;
            out_key_reg   <= (hit_reg && !clr_op_reg) ? fkey_ext[31:0] : 32'd0;
            out_value_reg <= (hit_reg && !clr_op_reg) ? fval_ext[31:0] : 32'd0;
            count_reg     <= total_next;
            empty_reg     <= (total_next == '0);
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign out_key     = out_key_reg;
    assign out_value   = out_value_reg;
    assign entry_count = count_reg;
    assign is_empty    = empty_reg;

endmodule

// ----- bench/chained_hash_table_engine_tb.sv -----
// Testbench for the chained hash table engine: random and directed table operations checked against a predictor.
module chained_hash_table_engine_tb;
    import cht_pkg::*;

    localparam int SLOTS = 256;
    localparam int NIL = SLOTS;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        status_t     status;
        logic        found;
        logic [31:0] out_key;
        logic [31:0] out_value;
        logic [8:0]  entry_count;
        logic        is_empty;
    } table_reply_t;

    class table_scoreboard;
        int          heads[SLOTS];
        int          links[SLOTS];
        logic [31:0] hashes[SLOTS];
        logic [31:0] keys[SLOTS];
        logic [31:0] values[SLOTS];
        int          free_top;
        int          high_water;
        int          total;
        table_reply_t pending[$];
        int          errors;
        int          replies;

        function void wipe();
            for (int i = 0; i < SLOTS; i++)
                heads[i] = NIL;
            free_top = NIL;
            high_water = 0;
            total = 0;
        endfunction

        function bit holds(logic [31:0] h);
            int n;
            n = heads[h[7:0]];
            for (int s = 0; s < SLOTS && n < NIL; s++)
            begin
                if (hashes[n] == h)
                    return 1;
                n = links[n];
            end
            return 0;
        endfunction

        function void note_request(mode_t m, logic [31:0] h, logic [31:0] k, logic [31:0] v);
            table_reply_t r;
            int b, n, p, slot, hole;
            r = '{ST_OK, 1'b0, 32'd0, 32'd0, 9'd0, 1'b0};
            b = h[7:0];
            slot = NIL;
            p = NIL;
            if (m == MODE_CLEAR)
                wipe();
            else
            begin
                n = heads[b];
                for (int s = 0; s < SLOTS && n < NIL; s++)
                begin
                    if (hashes[n] == h)
                    begin
                        slot = n;
                        break;
                    end
                    p = n;
                    n = links[n];
                end
                if (slot < NIL)
                begin
                    r.found = 1;
                    r.out_key = keys[slot];
                    r.out_value = values[slot];
                end
                if (m == MODE_INSERT)
                begin
                    if (r.found)
                        r.status = ST_DUPLICATE;
                    else if (total >= SLOTS)
                        r.status = ST_FULL;
                    else
                    begin
                        hole = NIL;
                        if (free_top < NIL)
                        begin
                            hole = free_top;
                            free_top = links[hole];
                        end
                        else if (high_water < SLOTS)
                        begin
                            hole = high_water;
                            high_water++;
                        end
                        if (hole < NIL)
                        begin
                            links[hole] = heads[b];
                            heads[b] = hole;
                            hashes[hole] = h;
                            keys[hole] = k;
                            values[hole] = v;
                            total++;
                        end
                        else
                            r.status = ST_FULL;
                    end
                end
                else if (!r.found)
                    r.status = ST_NOT_FOUND;
                else if (m == MODE_REMOVE)
                begin
                    if (p < NIL)
                        links[p] = links[slot];
                    else
                        heads[b] = links[slot];
                    links[slot] = free_top;
                    free_top = slot;
                    if (total > 0)
                        total--;
                end
            end
            r.entry_count = total[8:0];
            r.is_empty = (total == 0);
            pending.push_back(r);
        endfunction

        function void check_reply(table_reply_t a);
            table_reply_t e;
            replies++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d", $time, a.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status)
            begin
                $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
                errors++;
            end
            if (a.found !== e.found)
            begin
                $display("%0t: found exp %0d got %0d", $time, e.found, a.found);
                errors++;
            end
            if (a.out_key !== e.out_key)
            begin
                $display("%0t: out_key exp %h got %h", $time, e.out_key, a.out_key);
                errors++;
            end
            if (a.out_value !== e.out_value)
            begin
                $display("%0t: out_value exp %h got %h", $time, e.out_value, a.out_value);
                errors++;
            end
            if (a.entry_count !== e.entry_count)
            begin
                $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
                    a.entry_count);
                errors++;
            end
            if (a.is_empty !== e.is_empty)
            begin
                $display("%0t: is_empty exp %0d got %0d", $time, e.is_empty, a.is_empty);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [31:0] key_hash;
    logic [31:0] key;
    logic [31:0] entry_value;
    logic        done;
    logic [1:0]  status;
    logic        found;
    logic [31:0] out_key;
    logic [31:0] out_value;
    logic [8:0]  entry_count;
    logic        is_empty;

    table_scoreboard sb;
    int          idle_pct;
    int          stall_cycles;
    int          requests;
    logic [31:0] used_hashes[$];

    chained_hash_table_engine i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .key_hash   (key_hash),
        .key        (key),
        .entry_value(entry_value),
        .done       (done),
        .status     (status),
        .found      (found),
        .out_key    (out_key),
        .out_value  (out_value),
        .entry_count(entry_count),
        .is_empty   (is_empty)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_reply('{status_t'(status), found, out_key, out_value, entry_count,
                is_empty});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic issue(mode_t m, logic [31:0] h, logic [31:0] k, logic [31:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        mode <= m;
        key_hash <= h;
        key <= k;
        entry_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(m, h, k, v);
        if (m == MODE_INSERT)
            used_hashes.push_back(h);
        requests++;
    endtask

    function automatic logic [31:0] pick_hash();
        logic [31:0] h;
        case ($urandom_range(3))
            0: h = $urandom;
            1: h = {8'($urandom_range(3)), 16'h0, 8'($urandom_range(3))};
            default: h = used_hashes.size() ? used_hashes[$urandom_range(used_hashes.size() - 1)]
                                            : $urandom;
        endcase
        return h;
    endfunction

    task automatic random_phase(int count, int pct);
        int r;
        mode_t m;
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 50) m = MODE_INSERT;
            else if (r < 75) m = MODE_REMOVE;
            else if (r < 99) m = MODE_LOOKUP;
            else m = MODE_CLEAR;
            issue(m, pick_hash(), $urandom, $urandom);
        end
    endtask

    initial
    begin
        sb = new();
        sb.wipe();
        rst_n = 0;
        start = 0;
        mode = MODE_INSERT;
        key_hash = 0;
        key = 0;
        entry_value = 0;
        idle_pct = 0;
        requests = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;

        issue(MODE_LOOKUP, 32'h0, 32'h0, 32'h0);
        issue(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0);
        issue(MODE_INSERT, 32'h0, 32'h0, 32'h0);
        issue(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(MODE_INSERT, 32'h0000_0100, 32'h1234_5678, 32'hA5A5_5A5A);
        issue(MODE_INSERT, 32'h0000_0200, 32'h5A5A_A5A5, 32'h8765_4321);
        issue(MODE_INSERT, 32'h0000_0100, 32'h1, 32'h1);
        issue(MODE_LOOKUP, 32'h0000_0100, 32'h0, 32'h0);
        issue(MODE_LOOKUP, 32'h0000_0300, 32'h0, 32'h0);
        issue(MODE_REMOVE, 32'h0000_0100, 32'h0, 32'h0);
        issue(MODE_REMOVE, 32'h0000_0200, 32'h0, 32'h0);
        issue(MODE_INSERT, 32'h0000_0400, 32'hCAFE_0000, 32'h0000_BEEF);
        issue(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
        issue(MODE_CLEAR, 32'h0, 32'h0, 32'h0);
        issue(MODE_LOOKUP, 32'h0, 32'h0, 32'h0);

        // fill to capacity, then duplicate and full cases
        for (int i = 0; i < SLOTS; i++)
            issue(MODE_INSERT, $urandom & 32'hFFFF_FF00 | i, $urandom, $urandom);
        issue(MODE_INSERT, 32'h0000_0000 | 8'h07 | 32'hABCD_0000, 32'h1, 32'h2);
        issue(MODE_INSERT, sb.hashes[5], 32'h3, 32'h4);
        issue(MODE_REMOVE, sb.hashes[9], 32'h0, 32'h0);
        issue(MODE_INSERT, 32'h0BAD_0009, 32'h5, 32'h6);
        issue(MODE_CLEAR, 32'h0, 32'h0, 32'h0);
        used_hashes.delete();

        random_phase(300, 12);
        random_phase(300, 85);
        random_phase(300, 0);
        for (int s = 0; s < sb.total; s++)
            if (sb.holds(sb.hashes[s]) && $urandom_range(1))
                issue(MODE_REMOVE, sb.hashes[s], 32'h0, 32'h0);
        start <= 0;

        while (sb.pending.size() != 0 && stall_cycles < STALL_LIMIT)
            @(posedge clk);
        repeat (SLOTS + 20) @(posedge clk);
        $display("Ran %0d table transactions, %0d results checked, over three idle profiles",
            requests, sb.replies);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cht_pkg.sv
rtl/cht_ram.sv
rtl/chained_hash_table_engine.sv
bench/chained_hash_table_engine_tb.sv
